### src/signed_int_to_decimal_ascii_top_macros.svh
// Assertion macros used by the decimal text formatter back end.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_TOP_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_TOP_MACROS_SVH

`ifndef SYNTH

// Consequent must hold in the same cycle as the antecedent.
`define SITDA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sitda: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SITDA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sitda: next-cycle check failed");

`else

`define SITDA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SITDA_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

### src/sitda_pkg.sv
// Package with widths, character codes and types of the decimal text formatter.
package sitda_pkg;

  localparam int VALUE_W   = 32;
  localparam int CHAR_W    = 8;
  localparam int COUNT_W   = 4;
  localparam int NDIG      = 10;
  localparam int DIG_IDX_W = $clog2(NDIG);
  localparam int ITER_W    = $clog2(VALUE_W);
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0]  ASCII_NINE  = 8'd57;
  localparam logic [CHAR_W-1:0]  ASCII_MINUS = 8'd45;
  localparam logic [3:0]         DIGIT_MAX   = 4'd9;
  localparam logic [3:0]         BCD_ADJ_MIN = 4'd5;
  localparam logic [3:0]         BCD_ADJ_ADD = 4'd3;
  localparam logic [COUNT_W-1:0] MAX_CHARS   = 4'd11;
  localparam logic [ITER_W-1:0]  ITER_LAST   = ITER_W'(VALUE_W - 1);

  typedef struct packed {
    logic               negative;
    logic [VALUE_W-1:0] mag;
  } q_entry_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_CONV,
    B_SIZE,
    B_EMIT
  } back_state_t;

endpackage

### src/sitda_if.sv
// Handshake interfaces for the value input channel and the character output channel.
interface sitda_in_if import sitda_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sitda_out_if import sitda_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CHAR_W-1:0]  char_code;
  logic               last_char;
  logic [COUNT_W-1:0] total_count;

  modport source (output valid, output char_code, output last_char, output total_count,
                  input ready);
  modport sink   (input valid, input char_code, input last_char, input total_count,
                  output ready);
endinterface

### src/signed_int_to_decimal_ascii_top.sv
// Top level of the signed 32-bit integer to decimal ASCII text formatter.
// Each input beat carries one signed 32-bit value; the block answers with its
// decimal text as 1 to 11 output beats, one ASCII character per beat: a minus
// sign first for negative values, then the digits of the magnitude, most
// significant first and without leading zeros (zero gives a single '0', the
// most negative value gives "-2147483648"). The last beat of a value has
// last_char set and carries the character count in total_count; earlier beats
// carry a count of zero. Nothing is kept from one value to the next. The front
// end splits each value into sign and magnitude and parks it in a two-entry
// queue, so up to two values are taken while an earlier one is still being
// converted. The back end converts one value at a time with a shift-add-3
// loop that handles one magnitude bit per cycle: it loads the value, runs
// the conversion over every magnitude bit, finds the leading digit, then
// emits the characters one per beat as the sink takes them, and the
// converter loop sets the sustained rate. Output characters sit in a
// register, so the converter can start the next value as soon as the final
// character is loaded.
module signed_int_to_decimal_ascii_top import sitda_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  sitda_in_if.sink    in_ch,
  sitda_out_if.source out_ch
);

  logic     push_valid, push_ready;
  q_entry_t push_entry;
  logic     pop_valid, pop_ready;
  q_entry_t pop_entry;

  // Sign and magnitude split on the accepted beat.
  sitda_front u_front (
    .in_ch      (in_ch),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_entry (push_entry)
  );

  // Lets the front end keep taking values while the converter is busy.
  sitda_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry),
    .pop_ready  (pop_ready)
  );

  // Binary to BCD conversion and per-character output.
  sitda_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_entry (pop_entry),
    .pop_ready (pop_ready),
    .out_ch    (out_ch)
  );

endmodule

### src/sitda_front.sv
// Front end: accepts a value and splits it into sign and unsigned magnitude.
module sitda_front import sitda_pkg::*; (
  sitda_in_if.sink   in_ch,
  input  logic       push_ready,
  output logic       push_valid,
  output q_entry_t   push_entry
);

  logic [VALUE_W-1:0] raw;

  assign raw                 = in_ch.value;
  assign in_ch.ready         = push_ready;
  assign push_valid          = in_ch.valid;
  assign push_entry.negative = raw[VALUE_W-1];
  // The most negative value negates to itself, which read unsigned is its magnitude.
  assign push_entry.mag      = raw[VALUE_W-1] ? (~raw + VALUE_W'(1)) : raw;

endmodule

### src/sitda_queue.sv
// Short queue that decouples the front end from the converter.
module sitda_queue import sitda_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  input  q_entry_t push_entry,
  output logic     push_ready,
  output logic     pop_valid,
  output q_entry_t pop_entry,
  input  logic     pop_ready
);

  q_entry_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                push_ok, pop_ok;

  assign push_ready = (count_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_entry  = mem_r[rd_ptr_r];
  assign push_ok    = push_valid && push_ready;
  assign pop_ok     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push_ok && !pop_ok) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop_ok && !push_ok) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

### src/sitda_back.sv
// Back end: shift-add-3 binary to BCD conversion and character emission.
`include "signed_int_to_decimal_ascii_top_macros.svh"

module sitda_back import sitda_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        pop_valid,
  input  q_entry_t    pop_entry,
  output logic        pop_ready,
  sitda_out_if.source out_ch
);

  back_state_t                   state_r, state_nxt;
  logic [VALUE_W-1:0]            bin_r, bin_nxt;
  logic [NDIG-1:0][3:0]          bcd_r, bcd_nxt;
  logic [NDIG-1:0][3:0]          bcd_adj;
  logic                          neg_r, neg_nxt;
  logic [ITER_W-1:0]             iter_r, iter_nxt;
  logic [DIG_IDX_W-1:0]          dig_idx_r, dig_idx_nxt;
  logic [DIG_IDX_W-1:0]          top_idx;
  logic [COUNT_W-1:0]            total_r, total_nxt;
  logic                          sign_pend_r, sign_pend_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]             out_char_r, out_char_nxt;
  logic                          out_last_r, out_last_nxt;
  logic [COUNT_W-1:0]            out_count_r, out_count_nxt;
  logic                          out_free;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.char_code   = out_char_r;
  assign out_ch.last_char   = out_last_r;
  assign out_ch.total_count = out_count_r;
  assign out_free           = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt     = state_r;
    bin_nxt       = bin_r;
    bcd_nxt       = bcd_r;
    neg_nxt       = neg_r;
    iter_nxt      = iter_r;
    dig_idx_nxt   = dig_idx_r;
    total_nxt     = total_r;
    sign_pend_nxt = sign_pend_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_count_nxt = out_count_r;
    pop_ready     = 1'b0;
    top_idx       = '0;

    for (int i = 0; i < NDIG; i++) begin
      bcd_adj[i] = (bcd_r[i] >= BCD_ADJ_MIN) ? (bcd_r[i] + BCD_ADJ_ADD) : bcd_r[i];
    end
    // Highest nonzero digit; zero keeps index 0 so a single '0' comes out.
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_r[i] != '0) begin
        top_idx = DIG_IDX_W'(i);
      end
    end

    unique case (state_r)
      B_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          bin_nxt   = pop_entry.mag;
          neg_nxt   = pop_entry.negative;
          bcd_nxt   = '0;
          iter_nxt  = '0;
          state_nxt = B_CONV;
        end
      end
      B_CONV: begin
        {bcd_nxt, bin_nxt} = {bcd_adj, bin_r} << 1;
        iter_nxt           = iter_r + ITER_W'(1);
        if (iter_r == ITER_LAST) begin
          state_nxt = B_SIZE;
        end
      end
      B_SIZE: begin
        dig_idx_nxt   = top_idx;
        total_nxt     = COUNT_W'(top_idx) + COUNT_W'(1) + COUNT_W'(neg_r);
        sign_pend_nxt = neg_r;
        state_nxt     = B_EMIT;
      end
      B_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (sign_pend_r) begin
            out_char_nxt  = ASCII_MINUS;
            out_last_nxt  = 1'b0;
            out_count_nxt = '0;
            sign_pend_nxt = 1'b0;
          end else begin
            out_char_nxt  = ASCII_ZERO + {4'b0000, bcd_r[dig_idx_r]};
            out_last_nxt  = (dig_idx_r == '0);
            out_count_nxt = (dig_idx_r == '0) ? total_r : '0;
            if (dig_idx_r == '0) begin
              state_nxt = B_IDLE;
            end else begin
              dig_idx_nxt = dig_idx_r - DIG_IDX_W'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r       <= bin_nxt;
    bcd_r       <= bcd_nxt;
    neg_r       <= neg_nxt;
    iter_r      <= iter_nxt;
    dig_idx_r   <= dig_idx_nxt;
    total_r     <= total_nxt;
    sign_pend_r <= sign_pend_nxt;
    out_char_r  <= out_char_nxt;
    out_last_r  <= out_last_nxt;
    out_count_r <= out_count_nxt;
  end

  `SITDA_ASSERT_IMP(a_char_legal, clk, rst_n, out_valid_r, (out_char_r == ASCII_MINUS) || ((out_char_r >= ASCII_ZERO) && (out_char_r <= ASCII_NINE)))
  `SITDA_ASSERT_IMP(a_sign_not_last, clk, rst_n, out_valid_r && (out_char_r == ASCII_MINUS), !out_last_r && (out_count_r == '0))
  `SITDA_ASSERT_IMP(a_count_on_last, clk, rst_n, out_valid_r && out_last_r, (out_count_r != '0) && (out_count_r <= MAX_CHARS))
  `SITDA_ASSERT_IMP(a_digit_is_bcd, clk, rst_n, state_r == B_EMIT, bcd_r[dig_idx_r] <= DIGIT_MAX)
  `SITDA_ASSERT_NXT(a_size_after_conv, clk, rst_n, (state_r == B_CONV) && (iter_r == ITER_LAST), state_r == B_SIZE)

endmodule

### verif/decimal_text_checker.sv
// Checker that predicts the decimal text of every accepted value and compares the output beats.
module decimal_text_checker import sitda_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [VALUE_W-1:0] in_value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [CHAR_W-1:0]  out_char_code,
  input  logic               out_last_char,
  input  logic [COUNT_W-1:0] out_total_count,
  output int                 pending,
  output int                 fail_count
);

  localparam int DECIMAL_BASE = 10;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [CHAR_W-1:0]  char_code;
    logic               last_char;
    logic [COUNT_W-1:0] total_count;
  } char_beat_t;

  char_beat_t expected_chars[$];
  int         mismatches = 0;

  // Appends the characters of one value's text, sign first, then digits from the top.
  function automatic void push_decimal_text(input logic [VALUE_W-1:0] raw);
    logic               negative;
    logic [VALUE_W-1:0] mag;
    logic [3:0]         digits[NDIG];
    int                 ndig;
    logic [COUNT_W-1:0] total;
    char_beat_t         beat;
    negative = raw[VALUE_W-1];
    mag      = negative ? (~raw + 1'b1) : raw;
    ndig     = 0;
    do begin
      digits[ndig] = 4'(mag % DECIMAL_BASE);
      mag          = mag / DECIMAL_BASE;
      ndig++;
    end while (mag != 0 && ndig < NDIG);
    total = COUNT_W'(ndig + (negative ? 1 : 0));
    if (negative) begin
      beat.char_code   = ASCII_MINUS;
      beat.last_char   = 1'b0;
      beat.total_count = '0;
      expected_chars.push_back(beat);
    end
    for (int i = ndig - 1; i >= 0; i--) begin
      beat.char_code   = ASCII_ZERO + CHAR_W'(digits[i]);
      beat.last_char   = (i == 0);
      beat.total_count = (i == 0) ? total : '0;
      expected_chars.push_back(beat);
    end
  endfunction

  always @(posedge clk) begin : watch
    char_beat_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        push_decimal_text(in_value);
      end
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          if (mismatches < MAX_REPORTS) begin
            $display("unexpected beat: code %0d last %0b count %0d",
                     out_char_code, out_last_char, out_total_count);
          end
          mismatches++;
        end else begin
          want = expected_chars.pop_front();
          if (want.char_code !== out_char_code || want.last_char !== out_last_char ||
              want.total_count !== out_total_count) begin
            if (mismatches < MAX_REPORTS) begin
              $display("char mismatch: want %0d/%0b/%0d got %0d/%0b/%0d",
                       want.char_code, want.last_char, want.total_count,
                       out_char_code, out_last_char, out_total_count);
            end
            mismatches++;
          end
        end
      end
    end
    pending    <= expected_chars.size();
    fail_count <= mismatches;
  end

endmodule

### verif/signed_int_to_decimal_ascii_top_tb.sv
// Testbench top that drives values into the decimal text formatter and gives the verdict.
module signed_int_to_decimal_ascii_top_tb;
  import sitda_pkg::*;

  localparam int HALF_PERIOD      = 5;
  localparam int RESET_CYCLES     = 7;
  localparam int NUM_PHASES       = 4;
  localparam int RANDOM_PER_PHASE = 63;
  // This tail comfortably covers anything still in flight once the converter's
  // queue is empty.
  localparam int TAIL_CYCLES      = 60;
  // Worst case is roughly 300 values, each with eleven characters under long
  // receiver stalls; this limit is several times the time they need.
  localparam int RUN_LIMIT        = 5000000;

  // Idling phases: none, sender idle, receiver stalling, both.
  localparam int PHASE_NONE = 0;
  localparam int PHASE_SEND = 1;
  localparam int PHASE_RECV = 2;
  localparam int PHASE_BOTH = 3;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // Percentages of cycles in which each side holds back.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // Number of characters still owed by the block, and the failures so far.
  int pending;
  int fail_count;

  // Directed values: zero, single digits and their tens neighbors, the signed
  // extremes (including the most negative value, whose magnitude needs the
  // full unsigned range), the ten-digit boundary, and alternating bit patterns.
  logic [VALUE_W-1:0] directed_values [20] = '{
    0, 1, -1, 9, 10, -9, -10, 99, 100, -100,
    32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
    1000000000, 999999999, -1000000000,
    123456789, -123456789, 32'h5555_5555, 32'hAAAA_AAAA
  };

  sitda_in_if  in_if ();
  sitda_out_if out_if ();

  signed_int_to_decimal_ascii_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // The checker sees both channels, predicts each value's text on its own and
  // reports back only the number of outstanding characters and of failures.
  decimal_text_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_if.valid),
    .in_ready        (in_if.ready),
    .in_value        (in_if.value),
    .out_valid       (out_if.valid),
    .out_ready       (out_if.ready),
    .out_char_code   (out_if.char_code),
    .out_last_char   (out_if.last_char),
    .out_total_count (out_if.total_count),
    .pending         (pending),
    .fail_count      (fail_count)
  );

  always #HALF_PERIOD clk = ~clk;

  // Hard stop in case the block hangs or drops characters.
  initial begin
    #(RUN_LIMIT);
    $display("signed_int_to_decimal_ascii_top_tb NOT OK");
    $finish;
  end

  // The receiver decides afresh at every edge whether to take a beat, so its
  // stalls land on every character position, including the final one.
  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Picks a value of a random shape. Most values get a uniformly chosen digit
  // count so that short and long texts are equally common; some are plain
  // random words, which toggle every bit; the rest sit at or next to a power of ten.
  function automatic logic [VALUE_W-1:0] random_value();
    int unsigned shape;
    int unsigned ndig;
    int unsigned lo;
    int unsigned hi;
    int unsigned mag;
    logic        negative;
    shape    = $urandom_range(9);
    negative = 1'($urandom_range(1));
    if (shape < 2) begin
      return $urandom;
    end
    ndig = $urandom_range(NDIG, 1);
    lo   = 1;
    repeat (ndig - 1) lo = lo * 10;
    if (shape == 2) begin
      // One below, at, or one above a power of ten.
      mag = lo + $urandom_range(2) - 1;
    end else begin
      if (ndig == NDIG) begin
        hi = negative ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
        hi = lo * 10 - 1;
      end
      if (ndig == 1) begin
        lo = 0;
      end
      mag = $urandom_range(hi, lo);
    end
    return negative ? VALUE_W'(-mag) : VALUE_W'(mag);
  endfunction

  // Offers one value and returns at the edge where it is taken. Idle cycles
  // come before the beat, and the payload carries noise while valid is low.
  task automatic send_value(input logic [VALUE_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      in_if.value <= $urandom;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.value <= v;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // Holds the sender off until every outstanding character has come out.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    in_if.valid  = 1'b0;
    in_if.value  = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed values first, with neither side idling.
    foreach (directed_values[i]) begin
      send_value(directed_values[i]);
    end
    wait_drained();

    // Random values in each idling phase. Between phases the sender pauses
    // until the block has emptied, which also exercises a start from idle.
    for (int phase = PHASE_NONE; phase < NUM_PHASES; phase++) begin
      case (phase)
        PHASE_NONE: begin
          send_idle_pct  <= 0;
          recv_stall_pct <= 0;
        end
        PHASE_SEND: begin
          send_idle_pct  <= 69;
          recv_stall_pct <= 0;
        end
        PHASE_RECV: begin
          send_idle_pct  <= 0;
          recv_stall_pct <= 69;
        end
        default: begin
          send_idle_pct  <= 37;
          recv_stall_pct <= 37;
        end
      endcase
      @(posedge clk);
      repeat (RANDOM_PER_PHASE) send_value(random_value());
      wait_drained();
    end

    // Let the block sit idle for a while so a stray extra beat gets caught.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("signed_int_to_decimal_ascii_top_tb OK");
    end else begin
      $display("signed_int_to_decimal_ascii_top_tb NOT OK");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/sitda_pkg.sv
src/sitda_if.sv
src/sitda_front.sv
src/sitda_queue.sv
src/sitda_back.sv
src/signed_int_to_decimal_ascii_top.sv
verif/decimal_text_checker.sv
verif/signed_int_to_decimal_ascii_top_tb.sv
